// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DARGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DARGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dargc_pkg.sv -----
package dargc_pkg;

  // search engine status toward the control fsm
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } dargc_status_t;

  localparam int IDX_W       = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_PROCESSES = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_RESOURCES = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  COUNT_RESET       = 4'd8;

  localparam logic [1:0] OUTCOME_GRANTED = 2'd0;
  localparam logic [1:0] OUTCOME_QUEUED  = 2'd1;
  localparam logic [1:0] OUTCOME_REFUSED = 2'd2;
  localparam logic [1:0] OUTCOME_RANGE   = 2'd3;

endpackage

// ----- hdl/dargc_row_mem.sv -----
module dargc_row_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_data_r;

  // rows never written read as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/dargc_reach.sv -----
module dargc_reach #(
  parameter int NP = 8,
  parameter int NR = 8,
  parameter int PW = 3,
  parameter int RW = 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    from_res,
  input  logic [PW-1:0]           start_p,
  input  logic [RW-1:0]           start_r,
  output logic                    held_rd_en,
  output logic [RW-1:0]           held_rd_addr,
  input  logic [NP-1:0]           held_rd_data,
  output logic                    wait_rd_en,
  output logic [PW-1:0]           wait_rd_addr,
  input  logic [NR-1:0]           wait_rd_data,
  output dargc_pkg::dargc_status_t status
);

  logic          busy_r, busy_nxt;
  logic          phase_r, phase_nxt;
  logic          cur_res_r, cur_res_nxt;
  logic          done_r, done_nxt;
  logic          found_r, found_nxt;
  logic [NP-1:0] pend_p_r, pend_p_nxt, seen_p_r, seen_p_nxt, tgt_p_r, tgt_p_nxt;
  logic [NR-1:0] pend_r_r, pend_r_nxt, seen_r_r, seen_r_nxt, tgt_r_r, tgt_r_nxt;
  logic [NP-1:0] pbit;
  logic [NR-1:0] rbit;
  logic          hit;

  function automatic logic [PW-1:0] low_p(input logic [NP-1:0] v);
    logic [PW-1:0] idx;
    idx = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (v[i]) idx = PW'(i);
    end
    return idx;
  endfunction

  function automatic logic [RW-1:0] low_r(input logic [NR-1:0] v);
    logic [RW-1:0] idx;
    idx = '0;
    for (int i = NR - 1; i >= 0; i--) begin
      if (v[i]) idx = RW'(i);
    end
    return idx;
  endfunction

  assign pbit         = NP'(1) << start_p;
  assign rbit         = NR'(1) << start_r;
  assign held_rd_addr = low_r(pend_r_r);
  assign wait_rd_addr = low_p(pend_p_r);
  assign hit          = (|(seen_p_r & tgt_p_r)) | (|(seen_r_r & tgt_r_r));

  always_comb begin
    busy_nxt    = busy_r;
    phase_nxt   = phase_r;
    cur_res_nxt = cur_res_r;
    done_nxt    = 1'b0;
    found_nxt   = found_r;
    pend_p_nxt  = pend_p_r;
    pend_r_nxt  = pend_r_r;
    seen_p_nxt  = seen_p_r;
    seen_r_nxt  = seen_r_r;
    tgt_p_nxt   = tgt_p_r;
    tgt_r_nxt   = tgt_r_r;
    held_rd_en  = 1'b0;
    wait_rd_en  = 1'b0;
    if (!busy_r) begin
      if (start) begin
        busy_nxt   = 1'b1;
        phase_nxt  = 1'b0;
        found_nxt  = 1'b0;
        pend_p_nxt = from_res ? '0 : pbit;
        seen_p_nxt = from_res ? '0 : pbit;
        pend_r_nxt = from_res ? rbit : '0;
        seen_r_nxt = from_res ? rbit : '0;
        tgt_p_nxt  = from_res ? pbit : '0;
        tgt_r_nxt  = from_res ? '0 : rbit;
      end
    end else if (!phase_r) begin
      if (hit || (pend_p_r == '0 && pend_r_r == '0)) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        found_nxt = hit;
      end else if (|pend_r_r) begin
        held_rd_en  = 1'b1;
        pend_r_nxt  = pend_r_r & ~(NR'(1) << held_rd_addr);
        cur_res_nxt = 1'b1;
        phase_nxt   = 1'b1;
      end else begin
        wait_rd_en  = 1'b1;
        pend_p_nxt  = pend_p_r & ~(NP'(1) << wait_rd_addr);
        cur_res_nxt = 1'b0;
        phase_nxt   = 1'b1;
      end
    end else begin
      // row of the vertex picked last cycle is here now
      phase_nxt = 1'b0;
      if (cur_res_r) begin
        seen_p_nxt = seen_p_r | held_rd_data;
        pend_p_nxt = pend_p_r | (held_rd_data & ~seen_p_r);
      end else begin
        seen_r_nxt = seen_r_r | wait_rd_data;
        pend_r_nxt = pend_r_r | (wait_rd_data & ~seen_r_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_res_r <= cur_res_nxt;
    pend_p_r  <= pend_p_nxt;
    pend_r_r  <= pend_r_nxt;
    seen_p_r  <= seen_p_nxt;
    seen_r_r  <= seen_r_nxt;
    tgt_p_r   <= tgt_p_nxt;
    tgt_r_r   <= tgt_r_nxt;
  end

  assign status = '{busy: busy_r, done: done_r, found: found_r};

endmodule

// ----- hdl/deadlock_avoiding_resource_grant_core.sv -----
// deadlock-avoiding grant of single-instance resources
// in_*  : one request per transfer, process and resource index in in_tdata
// out_* : one outcome per request (granted, queued, refused, out of range)
// cfg_* : write-only registers num_processes (index 0), num_resources (index 1)
// a request to a free resource becomes a held-by edge, else a wait edge; the
// edge is kept only if it closes no cycle in the process/resource graph
// the graph rows live in two small memories with registered reads; a search
// engine walks reachability from the head of the new edge, one row at a time
// an accepted request passes S_CHECK, S_SEARCH (then S_WRD for a wait) and
// S_DONE before the outcome moves to the output register; an index out of
// range skips the search and goes from S_CHECK straight to S_DONE
// one request in work at a time: the next transfer can be taken from the cycle
// after the outcome moves to the output register
// the outcome waits in an output register; a stalled receiver holds back the
// next outcome but not the acceptance of the following request
// reset (synchronous, rst_n low): graph empty, all resources free, both
// counts 8; no clearing pass is needed
`include "assert_macros.svh"

module deadlock_avoiding_resource_grant_core #(
  parameter int MAX_PROCESSES = 8,
  parameter int MAX_RESOURCES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dargc_pkg::IN_TDATA_W-1:0]     in_tdata,     // process_index, resource_index
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dargc_pkg::OUT_TDATA_W-1:0]    out_tdata,    // outcome
  input  logic                                 cfg_wr_en,
  input  logic [dargc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dargc_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

  localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int CW = 6;
  localparam logic [CW-1:0] MAXP_C = CW'(MAX_PROCESSES);
  localparam logic [CW-1:0] MAXR_C = CW'(MAX_RESOURCES);

  // control states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_WRD    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                       state_r, state_nxt;
  logic [dargc_pkg::IDX_W-1:0]      p_r, r_r;
  logic                             grant_r, grant_nxt;
  logic [1:0]                       outcome_r, outcome_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [1:0]                       out_data_r, out_data_nxt;
  logic [dargc_pkg::CFG_DATA_W-1:0] num_proc_r, num_res_r;
  logic [MAX_RESOURCES-1:0]         free_r, free_nxt;

  logic [CW-1:0]            eff_p, eff_r;
  logic                     out_of_range;
  logic [PW-1:0]            p_addr;
  logic [RW-1:0]            r_addr;
  logic                     accept;
  logic                     out_load;
  logic                     search_start;
  logic                     in_search;
  logic                     grant_commit;

  // memory ports
  logic                     held_wr_en;
  logic                     held_rd_en;
  logic [RW-1:0]            held_rd_addr;
  logic [MAX_PROCESSES-1:0] held_rd_data;
  logic                     wait_wr_en;
  logic                     wait_rd_en, top_wait_rd_en, srch_wait_rd_en;
  logic [PW-1:0]            wait_rd_addr, srch_wait_rd_addr;
  logic [MAX_RESOURCES-1:0] wait_rd_data;

  dargc_pkg::dargc_status_t status;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign p_addr    = PW'(p_r);
  assign r_addr    = RW'(r_r);

  // counts above the array size clamp to it; zero makes every index invalid
  assign eff_p        = (CW'(num_proc_r) > MAXP_C) ? MAXP_C : CW'(num_proc_r);
  assign eff_r        = (CW'(num_res_r) > MAXR_C) ? MAXR_C : CW'(num_res_r);
  assign out_of_range = (CW'(p_r) >= eff_p) || (CW'(r_r) >= eff_r);

  assign search_start = (state_r == S_CHECK) && !out_of_range;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign in_search    = (state_r == S_SEARCH);
  assign grant_commit = in_search && status.done && !status.found && grant_r;

  // held-by rows: row r holds the process that owns resource r
  dargc_row_mem #(
    .DEPTH (MAX_RESOURCES),
    .WIDTH (MAX_PROCESSES),
    .AW    (RW)
  ) u_held_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (held_wr_en),
    .wr_addr (r_addr),
    .wr_data (MAX_PROCESSES'(1) << p_addr),
    .rd_en   (held_rd_en),
    .rd_addr (held_rd_addr),
    .rd_data (held_rd_data)
  );

  // wait-for rows: row p holds the resources process p waits on
  dargc_row_mem #(
    .DEPTH (MAX_PROCESSES),
    .WIDTH (MAX_RESOURCES),
    .AW    (PW)
  ) u_wait_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wait_wr_en),
    .wr_addr (p_addr),
    .wr_data (wait_rd_data | (MAX_RESOURCES'(1) << r_addr)),
    .rd_en   (wait_rd_en),
    .rd_addr (wait_rd_addr),
    .rd_data (wait_rd_data)
  );

  // the kept graph is acyclic, so a new edge u->v closes a cycle exactly
  // when v already reaches u; a grant starts at the process, a wait at
  // the resource
  dargc_reach #(
    .NP (MAX_PROCESSES),
    .NR (MAX_RESOURCES),
    .PW (PW),
    .RW (RW)
  ) u_reach (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (search_start),
    .from_res     (!free_r[r_addr]),
    .start_p      (p_addr),
    .start_r      (r_addr),
    .held_rd_en   (held_rd_en),
    .held_rd_addr (held_rd_addr),
    .held_rd_data (held_rd_data),
    .wait_rd_en   (srch_wait_rd_en),
    .wait_rd_addr (srch_wait_rd_addr),
    .wait_rd_data (wait_rd_data),
    .status       (status)
  );

  // the wait row is read again for the merge once the search is over;
  // reads and the one write of a request never overlap, so no forwarding
  assign wait_rd_en   = srch_wait_rd_en || top_wait_rd_en;
  assign wait_rd_addr = top_wait_rd_en ? p_addr : srch_wait_rd_addr;

  always_comb begin
    state_nxt      = state_r;
    grant_nxt      = grant_r;
    outcome_nxt    = outcome_r;
    free_nxt       = free_r;
    held_wr_en     = 1'b0;
    wait_wr_en     = 1'b0;
    top_wait_rd_en = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (out_of_range) begin
          outcome_nxt = dargc_pkg::OUTCOME_RANGE;
          state_nxt   = S_DONE;
        end else begin
          grant_nxt = free_r[r_addr];
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.done) begin
          if (status.found) begin
            outcome_nxt = dargc_pkg::OUTCOME_REFUSED;
            state_nxt   = S_DONE;
          end else if (grant_r) begin
            // a free resource has an empty row, so the new row is one bit
            held_wr_en       = 1'b1;
            free_nxt[r_addr] = 1'b0;
            outcome_nxt      = dargc_pkg::OUTCOME_GRANTED;
            state_nxt        = S_DONE;
          end else begin
            top_wait_rd_en = 1'b1;
            state_nxt      = S_WRD;
          end
        end
      end
      S_WRD: begin
        wait_wr_en  = 1'b1;
        outcome_nxt = dargc_pkg::OUTCOME_QUEUED;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = outcome_r;
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      free_r      <= '1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      free_r      <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r <= in_tdata[dargc_pkg::IDX_W-1:0];
      r_r <= in_tdata[2*dargc_pkg::IDX_W-1:dargc_pkg::IDX_W];
    end
    grant_r    <= grant_nxt;
    outcome_r  <= outcome_nxt;
    out_data_r <= out_data_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_proc_r <= dargc_pkg::COUNT_RESET;
      num_res_r  <= dargc_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dargc_pkg::REG_NUM_PROCESSES: num_proc_r <= cfg_wr_data;
        dargc_pkg::REG_NUM_RESOURCES: num_res_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(dargc_pkg::OUT_TDATA_W - 2){1'b0}}, out_data_r};

  `DARGC_ASSERT_IMP(a_busy_in_search, status.busy, in_search, "search busy outside search")
  `DARGC_ASSERT_IMP(a_done_in_search, status.done, in_search, "search done outside search")
  `DARGC_ASSERT_NXT(a_grant_takes, grant_commit, !free_r[r_addr], "granted resource still free")
  `DARGC_ASSERT_NXT(a_accept_check, accept, state_r == S_CHECK, "accepted request not checked")

endmodule

// ----- tb/sv/deadlock_avoiding_resource_grant_checker.sv -----
module deadlock_avoiding_resource_grant_checker
  import dargc_pkg::*;
#(
  parameter int MAX_PROCESSES = 8,
  parameter int MAX_RESOURCES = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // process_index, resource_index
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,    // outcome
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
  output int                     fail_count,
  output int                     pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  // mirror of the allocation graph
  logic [MAX_PROCESSES-1:0] owner_row [MAX_RESOURCES];  // bit p: resource held by p
  logic [MAX_RESOURCES-1:0] wait_row  [MAX_PROCESSES];  // bit r: process waits for r
  logic [MAX_RESOURCES-1:0] free_mask;
  logic [CFG_DATA_W-1:0]    proc_count;
  logic [CFG_DATA_W-1:0]    res_count;
  logic [1:0]               outcome_q [$];

  // peel off vertices with no edge into the remaining set; leftovers mean a cycle
  function automatic bit graph_is_cyclic();
    logic [MAX_PROCESSES-1:0] live_proc;
    logic [MAX_RESOURCES-1:0] live_res;
    bit                       stripped;
    live_proc = '1;
    live_res  = '1;
    stripped  = 1'b1;
    while (stripped) begin
      stripped = 1'b0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        if (live_proc[i] && (wait_row[i] & live_res) == '0) begin
          live_proc[i] = 1'b0;
          stripped     = 1'b1;
        end
      end
      for (int i = 0; i < MAX_RESOURCES; i++) begin
        if (live_res[i] && (owner_row[i] & live_proc) == '0) begin
          live_res[i] = 1'b0;
          stripped    = 1'b1;
        end
      end
    end
    return (|live_proc) || (|live_res);
  endfunction

  // apply one request to the mirrored graph and return its outcome
  function automatic logic [1:0] resolve_request(input logic [IDX_W-1:0] proc,
                                                 input logic [IDX_W-1:0] res);
    int unsigned              proc_lim;
    int unsigned              res_lim;
    logic [MAX_RESOURCES-1:0] prior_waits;
    proc_lim = (proc_count > MAX_PROCESSES) ? MAX_PROCESSES : proc_count;
    res_lim  = (res_count > MAX_RESOURCES) ? MAX_RESOURCES : res_count;
    if (proc >= proc_lim || res >= res_lim) return OUTCOME_RANGE;
    if (free_mask[res]) begin
      owner_row[res][proc] = 1'b1;
      free_mask[res]       = 1'b0;
      if (graph_is_cyclic()) begin
        owner_row[res][proc] = 1'b0;
        free_mask[res]       = 1'b1;
        return OUTCOME_REFUSED;
      end
      return OUTCOME_GRANTED;
    end
    prior_waits         = wait_row[proc];
    wait_row[proc][res] = 1'b1;
    if (graph_is_cyclic()) begin
      wait_row[proc] = prior_waits;
      return OUTCOME_REFUSED;
    end
    return OUTCOME_QUEUED;
  endfunction

  always @(posedge clk) begin
    logic [1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_RESOURCES; i++) owner_row[i] = '0;
      for (int i = 0; i < MAX_PROCESSES; i++) wait_row[i] = '0;
      free_mask  = '1;
      proc_count = COUNT_RESET;
      res_count  = COUNT_RESET;
      outcome_q.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_NUM_PROCESSES: proc_count = cfg_wr_data;
          REG_NUM_RESOURCES: res_count  = cfg_wr_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        outcome_q.push_back(resolve_request(in_tdata[IDX_W-1:0],
                                            in_tdata[2*IDX_W-1:IDX_W]));
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected outcome transfer, expected none, actual %0d",
                   $time, out_tdata[1:0]);
          fail_count <= fail_count + 1;
        end else begin
          want = outcome_q.pop_front();
          if (out_tdata[1:0] !== want) begin
            $display("%0t: outcome mismatch, expected %0d, actual %0d",
                     $time, want, out_tdata[1:0]);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= outcome_q.size();
    end
  end

endmodule

// ----- tb/sv/deadlock_avoiding_resource_grant_core_tb.sv -----
module deadlock_avoiding_resource_grant_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dargc_pkg::*;

  localparam int MAX_PROCESSES   = 8;
  localparam int MAX_RESOURCES   = 8;
  localparam int MAX_GAP         = 18;
  localparam int PHASE_ITEMS     = 250;
  localparam int RANDOM_PHASES   = 7;
  localparam int HOLD_PHASE      = 2;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 50;

  // how a side spaces its transfers within one phase
  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_SPARSE} pace_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;     // process_index, resource_index
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;    // outcome
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;
  int                     fail_count;
  int                     pending_count;

  pace_t sender_pace   = PACE_RANDOM;
  pace_t receiver_pace = PACE_RANDOM;
  bit    rx_hold_request = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  deadlock_avoiding_resource_grant_core #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // watches all three ports, mirrors the graph and scores every outcome
  deadlock_avoiding_resource_grant_checker #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // idle cycles before the next transfer on one side
  function automatic int draw_gap(input pace_t pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, MAX_GAP);
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
    endcase
  endfunction

  // register value: mostly a usable count, sometimes zero or above the maximum
  function automatic logic [CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return CFG_DATA_W'($urandom_range(MAX_PROCESSES + 1, 15));
      2:       return 4'd1;
      3:       return 4'd8;
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  // index mostly inside the active count, now and then anywhere in the field
  function automatic logic [IDX_W-1:0] pick_index(input logic [CFG_DATA_W-1:0] count);
    int unsigned lim;
    lim = (count > 8) ? 8 : count;
    if (lim == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 7));
    return IDX_W'($urandom_range(0, lim - 1));
  endfunction

  // one request transfer; valid stays up afterward so back-to-back items need no dip
  task automatic send_request(input logic [IDX_W-1:0] proc, input logic [IDX_W-1:0] res);
    int gap;
    gap = draw_gap(sender_pace);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 2*IDX_W){1'b0}}, res, proc};
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // stop offering and wait until every outcome has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // both registers, only ever written while the core is idle
  task automatic set_counts(input logic [CFG_DATA_W-1:0] procs,
                            input logic [CFG_DATA_W-1:0] ress);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_NUM_PROCESSES;
    cfg_wr_data <= procs;
    @(posedge clk);
    cfg_index   <= REG_NUM_RESOURCES;
    cfg_wr_data <= ress;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // receiver: per-outcome random stall, plus one long hold on request
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = draw_gap(receiver_pace);
      if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        gap             = HOLD_CYCLES;
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // stimulus and verdict
  initial begin
    logic [CFG_DATA_W-1:0] procs;
    logic [CFG_DATA_W-1:0] ress;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= REG_NUM_PROCESSES;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: grants, waits, refusals and range errors on a fresh graph
    set_counts(4'd8, 4'd8);
    send_request(3'd0, 3'd0);   // free resource, granted
    send_request(3'd1, 3'd1);   // granted
    send_request(3'd0, 3'd1);   // busy, p0 queues behind p1
    send_request(3'd0, 3'd1);   // same wait again, still queued
    send_request(3'd1, 3'd0);   // p1 waiting on r0 closes a four-vertex loop
    send_request(3'd0, 3'd0);   // asking for a resource it already holds
    send_request(3'd7, 3'd7);   // top corner, granted
    send_request(3'd7, 3'd0);   // p7 queues on r0
    send_request(3'd0, 3'd7);   // would close p0-r7-p7-r0 loop, refused
    drain();
    set_counts(4'd0, 4'd8);     // no processes: everything out of range
    send_request(3'd0, 3'd2);
    drain();
    set_counts(4'd8, 4'd0);     // no resources
    send_request(3'd3, 3'd0);
    drain();
    set_counts(4'd15, 4'd15);   // counts above the maximum clamp to eight
    send_request(3'd7, 3'd6);
    send_request(3'd5, 3'd6);
    drain();
    set_counts(4'd1, 4'd1);     // minimum counts
    send_request(3'd0, 3'd0);
    send_request(3'd1, 3'd0);
    send_request(3'd0, 3'd1);
    drain();
    set_counts(4'd9, 4'd3);
    send_request(3'd7, 3'd2);
    send_request(3'd5, 3'd3);
    send_request(3'd2, 3'd2);

    // random phases, each with fresh counts and pacing
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      procs = (ph == 0) ? 4'd8 : pick_count();
      ress  = (ph == 0) ? 4'd8 : pick_count();
      set_counts(procs, ress);
      sender_pace   = pace_t'($urandom_range(0, 2));
      receiver_pace = pace_t'($urandom_range(0, 2));
      if (ph == HOLD_PHASE) begin
        // long receiver hold while requests keep coming, so the core backs up
        sender_pace     = PACE_FULL;
        rx_hold_request = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(pick_index(procs), pick_index(ress));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- deadlock_avoiding_resource_grant_core.f -----
+incdir+hdl
hdl/dargc_pkg.sv
hdl/dargc_row_mem.sv
hdl/dargc_reach.sv
hdl/deadlock_avoiding_resource_grant_core.sv
tb/sv/deadlock_avoiding_resource_grant_checker.sv
tb/sv/deadlock_avoiding_resource_grant_core_tb.sv
